[rtl/lsrc_pkg.sv]
package lsrc_pkg;

  // Coordinate and window widths.
  localparam int COORD_BITS = 16;
  localparam int WIN_BITS   = 12;

  // Signed extent of one axis, and its magnitude as a fraction denominator.
  localparam int EXT_BITS = COORD_BITS + 1;
  localparam int DEN_BITS = COORD_BITS;

  // Signed numerator: a clamped window edge minus the start coordinate.
  localparam int NUM_BITS  = ((COORD_BITS > WIN_BITS) ? COORD_BITS : WIN_BITS + 1) + 1;
  localparam int MAG_BITS  = NUM_BITS - 1;
  localparam int QUO_BITS  = MAG_BITS;
  localparam int PROD_BITS = MAG_BITS + DEN_BITS;

  // Recomputed endpoint: start plus a signed rounded offset.
  localparam int END_BITS =
    ((COORD_BITS > QUO_BITS + 2) ? COORD_BITS : QUO_BITS + 2) + 1;

  // Pipeline depth.
  localparam int FRONT_STAGES = 5;
  localparam int DIV_STAGES   = QUO_BITS + 1;
  localparam int BACK_STAGES  = 2;
  localparam int PIPE_STAGES  = FRONT_STAGES + DIV_STAGES + BACK_STAGES;

  // Stream payload widths.
  localparam int IN_DATA_BITS   = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 1 + 4 * WIN_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 2;
  typedef logic [CFG_INDEX_BITS-1:0] reg_index_t;
  localparam reg_index_t REG_X_MIN = reg_index_t'(0);
  localparam reg_index_t REG_X_MAX = reg_index_t'(1);
  localparam reg_index_t REG_Y_MIN = reg_index_t'(2);
  localparam reg_index_t REG_Y_MAX = reg_index_t'(3);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [WIN_BITS-1:0]          win_t;
  typedef logic signed [END_BITS-1:0]   endp_t;

  typedef struct packed {
    win_t x_min;
    win_t x_max;
    win_t y_min;
    win_t y_max;
  } window_t;

  // Exact fraction: sign, magnitude of the numerator, positive denominator.
  typedef struct packed {
    logic                neg;
    logic [MAG_BITS-1:0] mag;
    logic [DEN_BITS-1:0] den;
  } frac_t;

  localparam frac_t FRAC_ZERO = '{neg: 1'b0, mag: MAG_BITS'(0), den: DEN_BITS'(1)};
  localparam frac_t FRAC_ONE  = '{neg: 1'b0, mag: MAG_BITS'(1), den: DEN_BITS'(1)};

  // Segment data that rides alongside the dividers.
  typedef struct packed {
    coord_t xa;
    coord_t ya;
    coord_t xb;
    coord_t yb;
    logic   pass;
    logic   clip_ok;
  } side_t;

  // One offset division: magnitude product over denominator, with sign.
  typedef struct packed {
    logic [PROD_BITS-1:0] m;
    logic [DEN_BITS-1:0]  d;
    logic                 neg;
  } div_in_t;

  typedef struct packed {
    logic [QUO_BITS-1:0] q;
    logic [DEN_BITS-1:0] rem;
    logic [DEN_BITS-1:0] d;
    logic                neg;
    logic                ovf;
  } div_out_t;

  // Point inside the window, edges inclusive.
  function automatic logic pt_inside(endp_t x, endp_t y, window_t w);
    logic in_x;
    logic in_y;
    in_x = (x >= $signed(END_BITS'(w.x_min))) && (x <= $signed(END_BITS'(w.x_max)));
    in_y = (y >= $signed(END_BITS'(w.y_min))) && (y <= $signed(END_BITS'(w.y_max)));
    return in_x && in_y;
  endfunction

endpackage

[rtl/lsrc_front.sv]
module lsrc_front (
  input  logic                                clk,
  input  logic [lsrc_pkg::FRONT_STAGES-1:0]   en,
  input  lsrc_pkg::coord_t                    start_x,
  input  lsrc_pkg::coord_t                    start_y,
  input  lsrc_pkg::coord_t                    end_x,
  input  lsrc_pkg::coord_t                    end_y,
  input  lsrc_pkg::window_t                   win,
  output lsrc_pkg::side_t                     side,
  output lsrc_pkg::div_in_t [3:0]             lane
);
  import lsrc_pkg::*;

  typedef struct packed {
    coord_t              xa;
    coord_t              ya;
    coord_t              xb;
    coord_t              yb;
    logic                pass;
    frac_t               t0x;
    frac_t               t1x;
    frac_t               t0y;
    frac_t               t1y;
    logic [DEN_BITS-1:0] adx;
    logic [DEN_BITS-1:0] ady;
    logic                dxn;
    logic                dyn;
  } fr_t;

  // Clamp a coordinate to the window (low edge first), minus the start.
  function automatic logic signed [NUM_BITS-1:0] clamp_off(coord_t v, coord_t base,
                                                           win_t lo, win_t hi);
    logic signed [NUM_BITS-1:0] vs;
    logic signed [NUM_BITS-1:0] los;
    logic signed [NUM_BITS-1:0] his;
    logic signed [NUM_BITS-1:0] c;
    vs  = NUM_BITS'(v);
    los = $signed(NUM_BITS'(lo));
    his = $signed(NUM_BITS'(hi));
    c   = (vs < los) ? los : ((vs > his) ? his : vs);
    return c - NUM_BITS'(base);
  endfunction

  // Fraction num / ext with the sign moved onto the numerator.
  function automatic frac_t make_frac(logic signed [NUM_BITS-1:0] num,
                                      logic signed [EXT_BITS-1:0] ext);
    logic [NUM_BITS-1:0] an;
    logic [EXT_BITS-1:0] ae;
    frac_t f;
    an    = num[NUM_BITS-1] ? NUM_BITS'(-num) : NUM_BITS'(num);
    ae    = ext[EXT_BITS-1] ? EXT_BITS'(-ext) : EXT_BITS'(ext);
    f.neg = (num != '0) && (num[NUM_BITS-1] ^ ext[EXT_BITS-1]);
    f.mag = an[MAG_BITS-1:0];
    f.den = ae[DEN_BITS-1:0];
    return f;
  endfunction

  // a < b from the two cross products a.mag*b.den and b.mag*a.den.
  function automatic logic frac_lt(logic an, logic bn,
                                   logic [PROD_BITS-1:0] p1, logic [PROD_BITS-1:0] p2);
    return (an && !bn) || ((an == bn) && (an ? (p1 > p2) : (p1 < p2)));
  endfunction

  function automatic logic [PROD_BITS-1:0] mul(logic [MAG_BITS-1:0] a,
                                               logic [DEN_BITS-1:0] b);
    return PROD_BITS'(a) * PROD_BITS'(b);
  endfunction

  logic signed [EXT_BITS-1:0] ext_x;
  logic signed [EXT_BITS-1:0] ext_y;
  fr_t                        s0_nxt;

  fr_t                  s0_r, s1_r, s2_r, s3_r;
  logic [PROD_BITS-1:0] pa1_r, pa2_r, pb1_r, pb2_r;
  logic [PROD_BITS-1:0] pc1_r, pc2_r;
  logic [PROD_BITS-1:0] m0_r, m1_r, m2_r, m3_r;
  side_t                side_r;
  div_in_t [3:0]        lane_r;

  // Stage 0: extents, entry and exit fractions, trivial accept.
  always_comb begin
    ext_x = EXT_BITS'(end_x) - EXT_BITS'(start_x);
    ext_y = EXT_BITS'(end_y) - EXT_BITS'(start_y);
    s0_nxt.xa   = start_x;
    s0_nxt.ya   = start_y;
    s0_nxt.xb   = end_x;
    s0_nxt.yb   = end_y;
    s0_nxt.pass = pt_inside(END_BITS'(start_x), END_BITS'(start_y), win) &&
                  pt_inside(END_BITS'(end_x), END_BITS'(end_y), win);
    s0_nxt.dxn  = ext_x[EXT_BITS-1];
    s0_nxt.dyn  = ext_y[EXT_BITS-1];
    if (ext_x == '0) begin
      s0_nxt.t0x = FRAC_ZERO;
      s0_nxt.t1x = FRAC_ONE;
      s0_nxt.adx = '0;
    end else begin
      s0_nxt.t0x = make_frac(clamp_off(start_x, start_x, win.x_min, win.x_max), ext_x);
      s0_nxt.t1x = make_frac(clamp_off(end_x, start_x, win.x_min, win.x_max), ext_x);
      s0_nxt.adx = s0_nxt.t0x.den;
    end
    if (ext_y == '0) begin
      s0_nxt.t0y = FRAC_ZERO;
      s0_nxt.t1y = FRAC_ONE;
      s0_nxt.ady = '0;
    end else begin
      s0_nxt.t0y = make_frac(clamp_off(start_y, start_y, win.y_min, win.y_max), ext_y);
      s0_nxt.t1y = make_frac(clamp_off(end_y, start_y, win.y_min, win.y_max), ext_y);
      s0_nxt.ady = s0_nxt.t0y.den;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_r <= s0_nxt;
    end
  end

  // Stage 1: cross products for the entry and exit comparisons.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_r  <= s0_r;
      pa1_r <= mul(s0_r.t0x.mag, s0_r.t0y.den);
      pa2_r <= mul(s0_r.t0y.mag, s0_r.t0x.den);
      pb1_r <= mul(s0_r.t1y.mag, s0_r.t1x.den);
      pb2_r <= mul(s0_r.t1x.mag, s0_r.t1y.den);
    end
  end

  // Stage 2: keep the larger entry and the smaller exit.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_r <= s1_r;
      if (frac_lt(s1_r.t0x.neg, s1_r.t0y.neg, pa1_r, pa2_r)) begin
        s2_r.t0x <= s1_r.t0y;
      end
      if (frac_lt(s1_r.t1y.neg, s1_r.t1x.neg, pb1_r, pb2_r)) begin
        s2_r.t1x <= s1_r.t1y;
      end
    end
  end

  // Stage 3: entry/exit cross products and the four offset numerators.
  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_r  <= s2_r;
      pc1_r <= mul(s2_r.t0x.mag, s2_r.t1x.den);
      pc2_r <= mul(s2_r.t1x.mag, s2_r.t0x.den);
      m0_r  <= mul(s2_r.t0x.mag, s2_r.adx);
      m1_r  <= mul(s2_r.t0x.mag, s2_r.ady);
      m2_r  <= mul(s2_r.t1x.mag, s2_r.adx);
      m3_r  <= mul(s2_r.t1x.mag, s2_r.ady);
    end
  end

  // Stage 4: entry below exit decides whether clipping goes on.
  always_ff @(posedge clk) begin
    if (en[4]) begin
      side_r.xa      <= s3_r.xa;
      side_r.ya      <= s3_r.ya;
      side_r.xb      <= s3_r.xb;
      side_r.yb      <= s3_r.yb;
      side_r.pass    <= s3_r.pass;
      side_r.clip_ok <= frac_lt(s3_r.t0x.neg, s3_r.t1x.neg, pc1_r, pc2_r);
      lane_r[0]      <= '{m: m0_r, d: s3_r.t0x.den, neg: s3_r.t0x.neg ^ s3_r.dxn};
      lane_r[1]      <= '{m: m1_r, d: s3_r.t0x.den, neg: s3_r.t0x.neg ^ s3_r.dyn};
      lane_r[2]      <= '{m: m2_r, d: s3_r.t1x.den, neg: s3_r.t1x.neg ^ s3_r.dxn};
      lane_r[3]      <= '{m: m3_r, d: s3_r.t1x.den, neg: s3_r.t1x.neg ^ s3_r.dyn};
    end
  end

  assign side = side_r;
  assign lane = lane_r;

endmodule

[rtl/lsrc_div.sv]
module lsrc_div (
  input  logic                              clk,
  input  logic [lsrc_pkg::DIV_STAGES-1:0]   en,
  input  lsrc_pkg::div_in_t                 din,
  output lsrc_pkg::div_out_t                dout
);
  import lsrc_pkg::*;

  logic [DEN_BITS-1:0] rem_r [DIV_STAGES];
  logic [QUO_BITS-1:0] low_r [DIV_STAGES];
  logic [QUO_BITS-1:0] q_r   [DIV_STAGES];
  logic [DEN_BITS-1:0] d_r   [DIV_STAGES];
  logic                neg_r [DIV_STAGES];
  logic                ovf_r [DIV_STAGES];

  logic [DEN_BITS:0]   trial [DIV_STAGES];
  logic                ge    [DIV_STAGES];
  logic [DEN_BITS-1:0] hi;

  assign hi = din.m[PROD_BITS-1:QUO_BITS];

  // Trial subtraction for each restoring step.
  always_comb begin
    trial[0] = '0;
    ge[0]    = 1'b0;
    for (int s = 1; s < DIV_STAGES; s++) begin
      trial[s] = {rem_r[s-1], low_r[s-1][QUO_BITS-1]};
      ge[s]    = trial[s] >= {1'b0, d_r[s-1]};
    end
  end

  // First stage flags a quotient too large to matter; then one bit per stage.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_r[0] <= hi;
      low_r[0] <= din.m[QUO_BITS-1:0];
      q_r[0]   <= '0;
      d_r[0]   <= din.d;
      neg_r[0] <= din.neg;
      ovf_r[0] <= hi >= din.d;
    end
    for (int s = 1; s < DIV_STAGES; s++) begin
      if (en[s]) begin
        rem_r[s] <= ge[s] ? DEN_BITS'(trial[s] - {1'b0, d_r[s-1]}) : trial[s][DEN_BITS-1:0];
        low_r[s] <= {low_r[s-1][QUO_BITS-2:0], 1'b0};
        q_r[s]   <= {q_r[s-1][QUO_BITS-2:0], ge[s]};
        d_r[s]   <= d_r[s-1];
        neg_r[s] <= neg_r[s-1];
        ovf_r[s] <= ovf_r[s-1];
      end
    end
  end

  assign dout.q   = q_r[DIV_STAGES-1];
  assign dout.rem = rem_r[DIV_STAGES-1];
  assign dout.d   = d_r[DIV_STAGES-1];
  assign dout.neg = neg_r[DIV_STAGES-1];
  assign dout.ovf = ovf_r[DIV_STAGES-1] | (low_r[DIV_STAGES-1] != '0);

endmodule

[rtl/lsrc_back.sv]
module lsrc_back (
  input  logic                               clk,
  input  logic [lsrc_pkg::BACK_STAGES-1:0]   en,
  input  lsrc_pkg::side_t                    side,
  input  lsrc_pkg::div_out_t [3:0]           lane,
  input  lsrc_pkg::window_t                  win,
  output logic                               visible,
  output lsrc_pkg::win_t                     clipped_start_x,
  output lsrc_pkg::win_t                     clipped_start_y,
  output lsrc_pkg::win_t                     clipped_end_x,
  output lsrc_pkg::win_t                     clipped_end_y
);
  import lsrc_pkg::*;

  // Base plus the offset rounded half up.
  function automatic endp_t round_end(coord_t base, div_out_t l);
    logic              nz;
    logic              negf;
    logic              up;
    logic [DEN_BITS:0] twor;
    logic [QUO_BITS:0] qq;
    endp_t             off;
    nz   = (l.q != '0) || (l.rem != '0);
    negf = l.neg && nz;
    twor = {l.rem, 1'b0};
    up   = negf ? (twor > {1'b0, l.d}) : (twor >= {1'b0, l.d});
    qq   = {1'b0, l.q} + (QUO_BITS + 1)'(up);
    off  = $signed(END_BITS'(qq));
    if (negf) begin
      off = -off;
    end
    return END_BITS'(base) + off;
  endfunction

  side_t side_r;
  endp_t nxa_r, nya_r, nxb_r, nyb_r;
  logic  ovf_r;
  logic  vis_nxt;
  logic  vis_r;
  win_t  csx_r, csy_r, cex_r, cey_r;

  // Stage 0: rebuild the clipped endpoints.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      side_r <= side;
      nxa_r  <= round_end(side.xa, lane[0]);
      nya_r  <= round_end(side.ya, lane[1]);
      nxb_r  <= round_end(side.xa, lane[2]);
      nyb_r  <= round_end(side.ya, lane[3]);
      ovf_r  <= lane[0].ovf | lane[1].ovf | lane[2].ovf | lane[3].ovf;
    end
  end

  assign vis_nxt = side_r.pass ||
                   (side_r.clip_ok && !ovf_r &&
                    pt_inside(nxa_r, nya_r, win) && pt_inside(nxb_r, nyb_r, win));

  // Stage 1: result register, zeroed when the segment is rejected.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      vis_r <= vis_nxt;
      if (side_r.pass) begin
        csx_r <= side_r.xa[WIN_BITS-1:0];
        csy_r <= side_r.ya[WIN_BITS-1:0];
        cex_r <= side_r.xb[WIN_BITS-1:0];
        cey_r <= side_r.yb[WIN_BITS-1:0];
      end else if (vis_nxt) begin
        csx_r <= nxa_r[WIN_BITS-1:0];
        csy_r <= nya_r[WIN_BITS-1:0];
        cex_r <= nxb_r[WIN_BITS-1:0];
        cey_r <= nyb_r[WIN_BITS-1:0];
      end else begin
        csx_r <= '0;
        csy_r <= '0;
        cex_r <= '0;
        cey_r <= '0;
      end
    end
  end

  assign visible         = vis_r;
  assign clipped_start_x = csx_r;
  assign clipped_start_y = csy_r;
  assign clipped_end_x   = cex_r;
  assign clipped_end_y   = cey_r;

endmodule

[rtl/line_segment_rect_clipper_top.sv]
// Stages: 5 setup stages, 17 divider stages (an overflow check, then one
// quotient bit per stage), 2 endpoint/output stages.
// Throughput: one segment per cycle unless the output stalls; each stage
// moves whenever the next is empty or moving, so bubbles close up under
// output backpressure.
// Reset (rst_n low, synchronous) empties the pipeline and sets the window
// to 0..4095 on both axes.
module line_segment_rect_clipper_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // start_x, start_y, end_x, end_y from bit 0 up
  input  logic [lsrc_pkg::IN_DATA_BITS-1:0]     in_tdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // visible, clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y
  // from bit 0 up, zero padded
  output logic [lsrc_pkg::OUT_DATA_BITS-1:0]    out_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  lsrc_pkg::reg_index_t                  cfg_index,
  input  lsrc_pkg::win_t                        cfg_data
);
  import lsrc_pkg::*;

  window_t                win_r;
  logic [PIPE_STAGES-1:0] v_r;
  logic [PIPE_STAGES:0]   rdy;
  side_t                  side_front;
  side_t                  side_d_r [DIV_STAGES];
  div_in_t  [3:0]         lane_in;
  div_out_t [3:0]         lane_out;
  logic                   vis;
  win_t                   csx, csy, cex, cey;

  // Window registers; configuration is always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '{x_min: '0, x_max: '1, y_min: '0, y_max: '1};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_X_MIN: win_r.x_min <= cfg_data;
        REG_X_MAX: win_r.x_max <= cfg_data;
        REG_Y_MIN: win_r.y_min <= cfg_data;
        REG_Y_MAX: win_r.y_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or its content moves on.
  always_comb begin
    rdy[PIPE_STAGES] = out_tready;
    for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int k = 1; k < PIPE_STAGES; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = v_r[PIPE_STAGES-1];

  lsrc_front u_front (
    .clk     (clk),
    .en      (rdy[FRONT_STAGES-1:0]),
    .start_x ($signed(in_tdata[0 +: COORD_BITS])),
    .start_y ($signed(in_tdata[COORD_BITS +: COORD_BITS])),
    .end_x   ($signed(in_tdata[2*COORD_BITS +: COORD_BITS])),
    .end_y   ($signed(in_tdata[3*COORD_BITS +: COORD_BITS])),
    .win     (win_r),
    .side    (side_front),
    .lane    (lane_in)
  );

  for (genvar i = 0; i < 4; i++) begin : g_lane
    lsrc_div u_div (
      .clk  (clk),
      .en   (rdy[FRONT_STAGES +: DIV_STAGES]),
      .din  (lane_in[i]),
      .dout (lane_out[i])
    );
  end

  // Segment data kept in step with the divider stages.
  always_ff @(posedge clk) begin
    if (rdy[FRONT_STAGES]) begin
      side_d_r[0] <= side_front;
    end
    for (int s = 1; s < DIV_STAGES; s++) begin
      if (rdy[FRONT_STAGES + s]) begin
        side_d_r[s] <= side_d_r[s-1];
      end
    end
  end

  lsrc_back u_back (
    .clk             (clk),
    .en              (rdy[FRONT_STAGES + DIV_STAGES +: BACK_STAGES]),
    .side            (side_d_r[DIV_STAGES-1]),
    .lane            (lane_out),
    .win             (win_r),
    .visible         (vis),
    .clipped_start_x (csx),
    .clipped_start_y (csy),
    .clipped_end_x   (cex),
    .clipped_end_y   (cey)
  );

  assign out_tdata = OUT_DATA_BITS'({cey, cex, csy, csx, vis});

  // A rejected segment carries all-zero coordinates.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[OUT_FIELD_BITS-1:1] == '0))
    else $error("rejected segment with nonzero coordinates");

  // With the output stage free to move, the input side is open.
  a_ready_open: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("input stalled while output stage can move");

  // A transaction in with none out adds exactly one item in flight.
  a_count_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !(out_tvalid && out_tready))
      |=> ($countones(v_r) == $past($countones(v_r)) + 1))
    else $error("pipeline item count off after input transaction");

  // A transaction out with none in removes exactly one item.
  a_count_out: assert property (@(posedge clk) disable iff (!rst_n)
    (!(in_tvalid && in_tready) && out_tvalid && out_tready)
      |=> ($countones(v_r) + 1 == $past($countones(v_r))))
    else $error("pipeline item count off after output transaction");

endmodule

[test/line_segment_rect_clipper_top_test.sv]
`timescale 1ns / 100ps

module line_segment_rect_clipper_top_test;
  import lsrc_pkg::*;

  localparam int LATENCY = 24;
  localparam int IDLE_LIMIT = 5000;

  // One clipped segment as it leaves the block.
  typedef struct packed {
    logic [11:0] ey;
    logic [11:0] ex;
    logic [11:0] sy;
    logic [11:0] sx;
    logic        vis;
  } clip_res_t;

  // One directed row: window, segment, and optionally a typed-in result.
  typedef struct {
    int        xlo, xhi, ylo, yhi;
    int        sx, sy, ex, ey;
    bit        typed;
    clip_res_t res;
  } seg_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [IN_DATA_BITS-1:0] in_tdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  reg_index_t cfg_index = REG_X_MIN;
  win_t cfg_data = '0;

  // Window copy held by the predictor.
  longint win_xlo = 0, win_xhi = 4095, win_ylo = 0, win_yhi = 4095;

  clip_res_t pending_clips[$];
  int mismatches = 0;
  int segs_sent = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  bit stall_long = 1'b0;
  bit stim_done = 1'b0;

  line_segment_rect_clipper_top DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Count cycles without any transaction; end the run on a hang.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("timeout: %0d results still pending", pending_clips.size());
      $display("[line_segment_rect_clipper_top] ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, results_seen);
    mismatches++;
  endtask

  // Exact fraction n/d with d > 0.
  typedef struct {
    longint n;
    longint d;
  } ratio_t;

  function automatic ratio_t make_ratio(longint n, longint e);
    ratio_t r;
    r.n = (e < 0) ? -n : n;
    r.d = (e < 0) ? -e : e;
    return r;
  endfunction

  // Numerators and denominators stay below 2^18, so cross products fit.
  function automatic bit ratio_lt(ratio_t a, ratio_t b);
    return a.n * b.d < b.n * a.d;
  endfunction

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // floor(t * e + 1/2), exact, ties upward, saturated at 2^40.
  function automatic longint round_offset(ratio_t t, longint e);
    longint p, q, lim;
    lim = 64'sd1 << 40;
    p = t.n * e;
    q = p / t.d;
    if (p - q * t.d < 0) q = q - 1;
    if (2 * (p - q * t.d) >= t.d) q = q + 1;
    if (q > lim) q = lim;
    if (q < -lim) q = -lim;
    return q;
  endfunction

  function automatic bit in_window(longint x, longint y);
    return x >= win_xlo && x <= win_xhi && y >= win_ylo && y <= win_yhi;
  endfunction

  // Clip one segment against the current window.
  function automatic clip_res_t clip_segment(longint xa, longint ya, longint xb, longint yb);
    clip_res_t r;
    longint dx, dy, nxa, nya, nxb, nyb;
    ratio_t t0x, t1x, t0y, t1y;
    bit vis;
    vis = 1'b0;
    if (in_window(xa, ya) && in_window(xb, yb)) begin
      vis = 1'b1;
    end else begin
      dx = xb - xa;
      dy = yb - ya;
      t0x = '{0, 1}; t1x = '{1, 1}; t0y = '{0, 1}; t1y = '{1, 1};
      if (dx != 0) begin
        t0x = make_ratio(clamp_to(xa, win_xlo, win_xhi) - xa, dx);
        t1x = make_ratio(clamp_to(xb, win_xlo, win_xhi) - xa, dx);
      end
      if (dy != 0) begin
        t0y = make_ratio(clamp_to(ya, win_ylo, win_yhi) - ya, dy);
        t1y = make_ratio(clamp_to(yb, win_ylo, win_yhi) - ya, dy);
      end
      if (ratio_lt(t0x, t0y)) t0x = t0y;
      if (ratio_lt(t1y, t1x)) t1x = t1y;
      if (ratio_lt(t0x, t1x)) begin
        nxb = xa + round_offset(t1x, dx);
        nyb = ya + round_offset(t1x, dy);
        nxa = xa + round_offset(t0x, dx);
        nya = ya + round_offset(t0x, dy);
        if (in_window(nxa, nya) && in_window(nxb, nyb)) begin
          vis = 1'b1;
          xa = nxa; ya = nya; xb = nxb; yb = nyb;
        end
      end
    end
    r = '0;
    if (vis) begin
      r.vis = 1'b1;
      r.sx = xa[11:0];
      r.sy = ya[11:0];
      r.ex = xb[11:0];
      r.ey = yb[11:0];
    end
    return r;
  endfunction

  // Writes one register; the caller drops cfg_valid after the last write.
  task automatic write_reg(input reg_index_t idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= win_t'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_X_MIN: win_xlo = value;
      REG_X_MAX: win_xhi = value;
      REG_Y_MIN: win_ylo = value;
      default:   win_yhi = value;
    endcase
  endtask

  // Waits for all results, lets the pipe drain, then loads a new window.
  task automatic set_window(input int xlo, input int xhi, input int ylo, input int yhi);
    while (pending_clips.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
    if (xlo != win_xlo) write_reg(REG_X_MIN, xlo);
    if (xhi != win_xhi) write_reg(REG_X_MAX, xhi);
    if (ylo != win_ylo) write_reg(REG_Y_MIN, ylo);
    if (yhi != win_yhi) write_reg(REG_Y_MAX, yhi);
    cfg_valid <= 1'b0;
  endtask

  // Offers one segment after an optional random gap; queues its expected result.
  task automatic send_segment(input int xa, input int ya, input int xb, input int yb,
                              input bit gaps, input bit typed, input clip_res_t want);
    int gap;
    gap = gaps ? $urandom_range(0, 17) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {16'(yb), 16'(xb), 16'(ya), 16'(xa)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_clips.push_back(typed ? want : clip_segment(xa, ya, xb, yb));
    segs_sent++;
  endtask

  function automatic int rand_coord(int lo, int hi);
    case ($urandom_range(0, 9))
      0: return -32768;
      1: return 32767;
      2, 3: return int'($urandom_range(0, 65535)) - 32768;
      default: return int'($urandom_range(0, hi - lo + 400)) + lo - 200;
    endcase
  endfunction

  // Receiver: random stalls, one long hold-off, then checks each result.
  initial begin
    clip_res_t got, want;
    int wait_n;
    @(posedge rst_n);
    forever begin
      if (stall_long) begin
        out_tready <= 1'b0;
        repeat (200) @(posedge clk);
        stall_long = 1'b0;
      end
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (segs_sent > 300) wait_n = 0;
      if (wait_n != 0) begin
        out_tready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      got = clip_res_t'(out_tdata[48:0]);
      results_seen++;
      if (pending_clips.size() == 0) begin
        report_mismatch("unexpected result", got.vis, -1);
      end else begin
        want = pending_clips.pop_front();
        if (got.vis != want.vis) report_mismatch("visible", got.vis, want.vis);
        if (got.sx != want.sx) report_mismatch("clipped_start_x", got.sx, want.sx);
        if (got.sy != want.sy) report_mismatch("clipped_start_y", got.sy, want.sy);
        if (got.ex != want.ex) report_mismatch("clipped_end_x", got.ex, want.ex);
        if (got.ey != want.ey) report_mismatch("clipped_end_y", got.ey, want.ey);
      end
    end
  end

  // Stimulus: directed table, then random windows and segments.
  initial begin
    seg_row_t rows[$];
    seg_row_t row;
    int ph, k, xlo, xhi, ylo, yhi;
    clip_res_t none;
    none = '0;
    // Reset window, inside passes unchanged, extremes and corners.
    rows.push_back('{0, 4095, 0, 4095, 10, 20, 30, 40, 1, '{12'd40, 12'd30, 12'd20, 12'd10, 1'b1}});
    rows.push_back('{0, 4095, 0, 4095, 0, 0, 4095, 4095, 1,
                     '{12'd4095, 12'd4095, 12'd0, 12'd0, 1'b1}});
    rows.push_back('{0, 4095, 0, 4095, -32768, -32768, -32768, -32768, 1, none});
    rows.push_back('{0, 4095, 0, 4095, 32767, 32767, 32767, 32767, 1, none});
    rows.push_back('{0, 4095, 0, 4095, -32768, -32768, 32767, 32767, 0, none});
    rows.push_back('{0, 4095, 0, 4095, 32767, -32768, -32768, 32767, 0, none});
    rows.push_back('{0, 4095, 0, 4095, -100, 50, 5000, 50, 0, none});
    rows.push_back('{0, 4095, 0, 4095, 50, -100, 50, 5000, 0, none});
    rows.push_back('{0, 4095, 0, 4095, -1, -1, 4096, 4096, 0, none});
    // Clipped window: ties in rounding, degenerate axis, point outside.
    rows.push_back('{100, 200, 100, 200, 0, 0, 300, 301, 0, none});
    rows.push_back('{100, 200, 100, 200, 99, 150, 202, 151, 0, none});
    rows.push_back('{100, 200, 100, 200, 300, 0, 0, 301, 0, none});
    rows.push_back('{100, 200, 100, 200, 50, 50, 50, 50, 1, none});
    rows.push_back('{100, 200, 100, 200, 150, 150, 150, 150, 1,
                     '{12'd150, 12'd150, 12'd150, 12'd150, 1'b1}});
    rows.push_back('{100, 200, 100, 200, 0, 0, 10, 300, 0, none});
    // Single pixel and inverted window.
    rows.push_back('{4095, 4095, 0, 0, 4095, 0, 4095, 0, 1,
                     '{12'd0, 12'd4095, 12'd0, 12'd4095, 1'b1}});
    rows.push_back('{4095, 4095, 0, 0, 4000, 0, 5000, 0, 0, none});
    rows.push_back('{300, 200, 300, 200, 250, 250, 260, 260, 1, none});
    rows.push_back('{300, 200, 300, 200, -32768, -32768, 32767, 32767, 1, none});
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) begin
      row = rows[i];
      if (row.xlo != win_xlo || row.xhi != win_xhi || row.ylo != win_ylo || row.yhi != win_yhi)
      begin
        // Stop offering before the pipe drains for the new window.
        in_tvalid <= 1'b0;
        set_window(row.xlo, row.xhi, row.ylo, row.yhi);
      end
      send_segment(row.sx, row.sy, row.ex, row.ey, 1'b1, row.typed, row.res);
    end
    in_tvalid <= 1'b0;
    // Random phases, each with its own window.
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin xlo = 0; xhi = 4095; ylo = 0; yhi = 4095; end
        1: begin xlo = 1000; xhi = 1010; ylo = 2000; yhi = 2003; end
        2: begin xlo = 4095; xhi = 0; ylo = 0; yhi = 4095; end
        default: begin
          xlo = $urandom_range(0, 4095); xhi = $urandom_range(xlo, 4095);
          ylo = $urandom_range(0, 4095); yhi = $urandom_range(ylo, 4095);
        end
      endcase
      set_window(xlo, xhi, ylo, yhi);
      if (ph == 1) stall_long = 1'b1;
      for (k = 0; k < 72; k++) begin
        if (k == 36) begin
          in_tvalid <= 1'b0;
          while (pending_clips.size() != 0) @(posedge clk);
        end
        send_segment(rand_coord(xlo < xhi ? xlo : xhi, xhi > xlo ? xhi : xlo),
                     rand_coord(ylo, yhi),
                     rand_coord(xlo < xhi ? xlo : xhi, xhi > xlo ? xhi : xlo),
                     rand_coord(ylo, yhi), ph != 1 || k > 40, 1'b0, none);
      end
      in_tvalid <= 1'b0;
    end
    while (pending_clips.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d segments over reset, narrow, inverted and random windows;",
             segs_sent);
    $display("%0d results checked, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0)
      $display("[line_segment_rect_clipper_top] OK");
    else
      $display("[line_segment_rect_clipper_top] ERROR");
    $finish;
  end

endmodule
